[rtl/core/assert_macros.svh]
// Assertion macros shared by the display scanner RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define FSTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Expression must never be true at a rising edge outside reset.
`define FSTS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

[rtl/core/fsts_pkg.sv]
// Shared types, constants and the segment decoder of the display scanner.
// Depends on nothing; imported by every module of the block.
package fsts_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = $clog2(DIGIT_COUNT);
	localparam int COUNT_W     = $clog2(DIGIT_COUNT + 1);

	localparam logic [7:0]  CHAR_DOT    = 8'h2E;
	localparam logic [7:0]  CHAR_SPACE  = 8'h20;
	localparam logic [7:0]  CHAR_P      = 8'h50;
	localparam logic [7:0]  CHAR_A      = 8'h41;
	localparam logic [7:0]  CHAR_I      = 8'h49;
	localparam logic [7:0]  CHAR_ZERO   = 8'h30;

	localparam logic [9:0]  DWELL_RESET = 10'd54;
	localparam logic [15:0] TPM_RESET   = 16'd1000;
	localparam logic [15:0] MS_MAX      = 16'hFFFF;
	localparam logic [6:0]  SEG_BLANK   = 7'h7F;

	// Configuration register indexes.
	localparam logic REG_DIGIT_DWELL  = 1'b0;
	localparam logic REG_TICKS_PER_MS = 1'b1;

	typedef enum logic [1:0] {
		CMD_CHAR  = 2'd0,
		CMD_SHOW  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef logic [DIGIT_COUNT-1:0][7:0] chars_t;
	typedef logic [DIGIT_COUNT-1:0]      points_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  character;
		logic [15:0] show_ms;
	} item_t;

	// One item leaving the input register, with its fields.
	typedef struct packed {
		logic  go;
		item_t item;
	} step_t;

	typedef struct packed {
		logic                   hit;
		logic [DIGIT_COUNT-1:0] digit_enable;
		logic                   dot_off;
		logic [6:0]             segments_off;
	} result_t;

	// Active-low segment pattern, segments a..g in bits 0..6.
	function automatic logic [6:0] seg_pattern(input logic [7:0] c);
		logic [6:0] p;
		case (c)
			CHAR_ZERO + 8'd0: p = 7'h40;
			CHAR_ZERO + 8'd1: p = 7'h79;
			CHAR_ZERO + 8'd2: p = 7'h24;
			CHAR_ZERO + 8'd3: p = 7'h30;
			CHAR_ZERO + 8'd4: p = 7'h19;
			CHAR_ZERO + 8'd5: p = 7'h12;
			CHAR_ZERO + 8'd6: p = 7'h02;
			CHAR_ZERO + 8'd7: p = 7'h78;
			CHAR_ZERO + 8'd8: p = 7'h00;
			CHAR_ZERO + 8'd9: p = 7'h10;
			CHAR_P:           p = 7'h0C;
			CHAR_A:           p = 7'h08;
			CHAR_I:           p = 7'h4F;
			default:          p = SEG_BLANK;
		endcase
		return p;
	endfunction

endpackage

[rtl/core/four_digit_segment_text_scanner.sv]
// Top level of the four-digit seven-segment text scanner.
// Depends on fsts_pkg, fsts_text_buf, fsts_scan and assert_macros.svh.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   command, character, show_ms
//   result    out        result_valid / result_stall  digit_enable, dot_off, segments_off
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each item passes through the input register and then the result register
// on its way to its result beat; one item is taken per cycle while item_stall is low.
// The throughput is set by the single result register: while a result beat
// waits under result_stall, the input register holds one more item, and only
// then does item_stall rise.
// Reset (arst_n low) clears all control state at once; no clearing pass.
`include "assert_macros.svh"

module four_digit_segment_text_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  character,
	input  logic [15:0] show_ms,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  digit_enable,
	output logic        dot_off,
	output logic [6:0]  segments_off,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import fsts_pkg::*;

	// Configuration registers. The user must write them only while the block is idle;
	// the block itself does not enforce this, and writes are always taken.
	logic [9:0]  digit_dwell_q;
	logic [15:0] ticks_per_ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_dwell_q  <= DWELL_RESET;
			ticks_per_ms_q <= TPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DIGIT_DWELL) begin
				digit_dwell_q <= cfg_data[9:0];
			end
			if (cfg_index == REG_TICKS_PER_MS) begin
				ticks_per_ms_q <= cfg_data;
			end
		end
	end

	// Input register. The item held here is executed in the cycle it moves
	// on, which happens whenever the result register is empty or is being
	// emptied by a result beat.
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    accept;
	step_t   step;
	result_t res;
	chars_t  shown_chars;
	points_t shown_points;

	assign advance    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd       <= cmd_t'(command);
			item_s1.character <= character;
			item_s1.show_ms   <= show_ms;
		end
	end

	assign step.go   = valid_s1 && advance;
	assign step.item = item_s1;

	// The text buffer hands over the shown store as it will be after this
	// item, so a show item drives its first digit from the new contents.
	fsts_text_buf u_text_buf (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.shown_chars_d  (shown_chars),
		.shown_points_d (shown_points)
	);

	fsts_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.digit_dwell  (digit_dwell_q),
		.ticks_per_ms (ticks_per_ms_q),
		.shown_chars  (shown_chars),
		.shown_points (shown_points),
		.res          (res)
	);

	// Result register. It loads on every executed item; an item that gives
	// no result leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= step.go && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step.go && res.hit) begin
			digit_enable <= res.digit_enable;
			dot_off      <= res.dot_off;
			segments_off <= res.segments_off;
		end
	end

	`FSTS_ASSERT(a_stall_only_when_full, clk, arst_n,
		item_stall |-> valid_s1 && result_valid && result_stall)
	`FSTS_ASSERT(a_waiting_result_kept, clk, arst_n,
		(result_valid && result_stall) |=> result_valid && $stable(digit_enable))

endmodule

[rtl/core/fsts_text_buf.sv]
// Pending text line and shown store of the display scanner.
// Depends on fsts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsts_text_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  fsts_pkg::step_t  step,
	output fsts_pkg::chars_t shown_chars_d,
	output fsts_pkg::points_t shown_points_d
);
	import fsts_pkg::*;

	chars_t               pending_chars_q;
	chars_t               pending_chars_d;
	points_t              pending_points_q, pending_points_d;
	logic [COUNT_W-1:0]   placed_count_q, placed_count_d;
	logic [COUNT_W-1:0]   period_count_q, period_count_d;
	logic                 tail_checked_q, tail_checked_d;
	chars_t               shown_chars_q;
	points_t              shown_points_q;

	chars_t               fill_chars;
	points_t              fill_points;
	logic [COUNT_W-1:0]   shift;
	logic [2*DIGIT_COUNT-1:0] pts_wide, mask_wide;
	logic                 is_dot, dots_left;
	logic [DIGIT_W-1:0]   prev_digit;

	assign shift     = COUNT_W'(DIGIT_COUNT) - placed_count_q;
	assign is_dot    = (step.item.character == CHAR_DOT);
	assign dots_left = (period_count_q < COUNT_W'(DIGIT_COUNT));
	assign prev_digit = (placed_count_q == '0) ? '0
	                  : DIGIT_W'(placed_count_q - COUNT_W'(1));

	// Right-justified copy of the pending line, spaces on the left.
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (COUNT_W'(i) < shift) begin
				fill_chars[i] = CHAR_SPACE;
			end else begin
				fill_chars[i] = pending_chars_q[DIGIT_W'(COUNT_W'(i) - shift)];
			end
		end
		pts_wide    = {{DIGIT_COUNT{1'b0}}, pending_points_q} << shift;
		mask_wide   = ((2*DIGIT_COUNT)'(1) << shift) - (2*DIGIT_COUNT)'(1);
		fill_points = pts_wide[DIGIT_COUNT-1:0] | mask_wide[DIGIT_COUNT-1:0];
	end

	always_comb begin
		pending_chars_d  = pending_chars_q;
		pending_points_d = pending_points_q;
		placed_count_d   = placed_count_q;
		period_count_d   = period_count_q;
		tail_checked_d   = tail_checked_q;
		shown_chars_d    = shown_chars_q;
		shown_points_d   = shown_points_q;
		if (step.go && step.item.cmd == CMD_CHAR) begin
			if (placed_count_q < COUNT_W'(DIGIT_COUNT)) begin
				if (dots_left && is_dot) begin
					pending_points_d[prev_digit] = 1'b0;
					period_count_d = period_count_q + COUNT_W'(1);
				end else begin
					pending_chars_d[DIGIT_W'(placed_count_q)] = step.item.character;
					placed_count_d = placed_count_q + COUNT_W'(1);
				end
			end else if (!tail_checked_q) begin
				if (dots_left && is_dot) begin
					pending_points_d[DIGIT_COUNT-1] = 1'b0;
				end
				tail_checked_d = 1'b1;
			end
		end else if (step.go && step.item.cmd == CMD_SHOW) begin
			shown_chars_d    = fill_chars;
			shown_points_d   = fill_points;
			pending_points_d = '1;
			placed_count_d   = '0;
			period_count_d   = '0;
			tail_checked_d   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pending_chars_q <= pending_chars_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_points_q <= '1;
			placed_count_q   <= '0;
			period_count_q   <= '0;
			tail_checked_q   <= 1'b0;
			shown_chars_q    <= {DIGIT_COUNT{CHAR_SPACE}};
			shown_points_q   <= '1;
		end else begin
			pending_points_q <= pending_points_d;
			placed_count_q   <= placed_count_d;
			period_count_q   <= period_count_d;
			tail_checked_q   <= tail_checked_d;
			shown_chars_q    <= shown_chars_d;
			shown_points_q   <= shown_points_d;
		end
	end

	`FSTS_ASSERT(a_counts_bounded, clk, arst_n,
		placed_count_q <= COUNT_W'(DIGIT_COUNT) && period_count_q <= COUNT_W'(DIGIT_COUNT))
	`FSTS_ASSERT(a_tail_only_when_full, clk, arst_n,
		tail_checked_q |-> placed_count_q == COUNT_W'(DIGIT_COUNT))

endmodule

[rtl/core/fsts_scan.sv]
// Multiplexed scan timing and digit drive of the display scanner.
// Depends on fsts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsts_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  fsts_pkg::step_t   step,
	input  logic [9:0]        digit_dwell,
	input  logic [15:0]       ticks_per_ms,
	input  fsts_pkg::chars_t  shown_chars,
	input  fsts_pkg::points_t shown_points,
	output fsts_pkg::result_t res
);
	import fsts_pkg::*;

	logic               scanning_q, scanning_d;
	logic [DIGIT_W-1:0] scan_digit_q, scan_digit_d;
	logic [9:0]         dwell_count_q, dwell_count_d;
	logic [15:0]        ms_prescale_q, ms_prescale_d;
	logic [15:0]        elapsed_ms_q, elapsed_ms_d;
	logic [15:0]        show_limit_q, show_limit_d;

	logic [16:0]        presc_inc;
	logic [10:0]        dwell_inc;
	logic               drive;
	logic [DIGIT_W-1:0] drive_digit;

	assign presc_inc = {1'b0, ms_prescale_q} + 17'd1;
	assign dwell_inc = {1'b0, dwell_count_q} + 11'd1;

	always_comb begin
		scanning_d    = scanning_q;
		scan_digit_d  = scan_digit_q;
		dwell_count_d = dwell_count_q;
		ms_prescale_d = ms_prescale_q;
		elapsed_ms_d  = elapsed_ms_q;
		show_limit_d  = show_limit_q;
		drive         = 1'b0;
		res           = '0;
		if (step.go) begin
			case (step.item.cmd)
				CMD_SHOW: begin
					show_limit_d  = step.item.show_ms;
					elapsed_ms_d  = '0;
					ms_prescale_d = '0;
					scan_digit_d  = '0;
					dwell_count_d = '0;
					scanning_d    = (step.item.show_ms != '0);
					drive         = scanning_d;
				end
				CMD_CLEAR: begin
					scanning_d       = 1'b0;
					res.hit          = 1'b1;
					res.digit_enable = '0;
					res.dot_off      = 1'b1;
					res.segments_off = SEG_BLANK;
				end
				CMD_TICK: begin
					if (scanning_q) begin
						if (presc_inc >= {1'b0, ticks_per_ms}) begin
							ms_prescale_d = '0;
							if (elapsed_ms_q != MS_MAX) begin
								elapsed_ms_d = elapsed_ms_q + 16'd1;
							end
						end else begin
							ms_prescale_d = presc_inc[15:0];
						end
						if (dwell_inc < {1'b0, digit_dwell}) begin
							dwell_count_d = dwell_inc[9:0];
						end else begin
							dwell_count_d = '0;
							if (scan_digit_q != DIGIT_W'(DIGIT_COUNT - 1)) begin
								scan_digit_d = scan_digit_q + DIGIT_W'(1);
								drive = 1'b1;
							end else if (elapsed_ms_d < show_limit_q) begin
								scan_digit_d = '0;
								drive = 1'b1;
							end else begin
								scanning_d = 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		drive_digit = scan_digit_d;
		if (drive) begin
			res.hit          = 1'b1;
			res.digit_enable = DIGIT_COUNT'(1) << drive_digit;
			res.dot_off      = shown_points[drive_digit];
			res.segments_off = seg_pattern(shown_chars[drive_digit]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q    <= 1'b0;
			scan_digit_q  <= '0;
			dwell_count_q <= '0;
			ms_prescale_q <= '0;
			elapsed_ms_q  <= '0;
			show_limit_q  <= '0;
		end else begin
			scanning_q    <= scanning_d;
			scan_digit_q  <= scan_digit_d;
			dwell_count_q <= dwell_count_d;
			ms_prescale_q <= ms_prescale_d;
			elapsed_ms_q  <= elapsed_ms_d;
			show_limit_q  <= show_limit_d;
		end
	end

	`FSTS_ASSERT(a_scan_has_limit, clk, arst_n, scanning_q |-> show_limit_q != '0)
	`FSTS_NEVER(a_idle_tick_silent, clk, arst_n,
		step.go && step.item.cmd == CMD_TICK && !scanning_q && res.hit)

endmodule
